// ===== design/ift_pkg.sv =====
// ----------------------------------------------------------------------------
// ift_pkg
// Shared types, codes and decode tables of the instruction fetch tracer.
// ----------------------------------------------------------------------------
package ift_pkg;

    typedef enum logic [1:0] {
        KIND_FETCH  = 2'd0,
        KIND_VECTOR = 2'd1,
        KIND_OTHER  = 2'd2,
        KIND_SPARE  = 2'd3
    } ift_kind_t;

    localparam logic REC_INSN   = 1'b0;
    localparam logic REC_VECTOR = 1'b1;

    localparam logic [4:0] MODE_PCR  = 5'd15;
    localparam logic [4:0] MODE_PCRL = 5'd16;

    // length codes: 1..4 fixed, otherwise sized by M or X
    localparam logic [2:0] LEN_M = 3'd5;
    localparam logic [2:0] LEN_X = 3'd6;
    localparam logic [2:0] LEN_MAX = 3'd4;

    typedef struct packed {
        ift_kind_t   mode;
        logic [7:0]  bank;
        logic [15:0] address;
        logic [7:0]  data;
        logic        m_flag;
        logic        x_flag;
    } ift_item_t;

    typedef struct packed {
        logic        record_kind;
        logic [7:0]  record_bank;
        logic [15:0] record_address;
        logic [7:0]  opcode;
        logic [23:0] operand;
        logic [2:0]  length;
        logic [4:0]  addr_mode;
        logic [15:0] branch_target;
        logic [15:0] vector_value;
    } ift_result_t;

    localparam logic [4:0] MODE_TAB [256] = '{
        5,9,5,22,3,3,3,20,5,0,4,5,1,1,1,2,
        15,7,19,23,3,10,10,8,5,14,4,5,1,12,12,13,
        1,9,2,22,3,3,3,20,5,0,4,5,1,1,1,2,
        15,7,19,23,10,10,10,8,5,14,4,5,12,12,12,13,
        5,9,0,22,24,3,3,20,5,0,4,5,1,1,1,2,
        15,7,19,23,24,10,10,8,5,14,5,5,2,12,12,13,
        5,9,16,22,3,3,3,20,5,0,4,5,17,1,1,2,
        15,7,19,23,10,10,10,8,5,14,5,5,21,12,12,13,
        15,9,16,22,3,3,3,20,5,0,5,5,1,1,1,2,
        15,7,19,23,10,10,11,8,5,14,5,5,1,12,12,13,
        0,9,0,22,3,3,3,20,5,0,5,5,1,1,1,2,
        15,7,19,23,10,10,11,8,5,14,5,5,12,12,14,13,
        0,9,0,22,3,3,3,20,5,0,5,5,1,1,1,2,
        15,7,19,23,3,10,10,8,5,14,5,5,18,12,12,13,
        0,9,0,22,3,3,3,20,5,0,5,5,1,1,1,2,
        15,7,19,23,0,10,10,8,5,14,5,5,21,12,12,13
    };

    localparam logic [2:0] LEN_TAB [256] = '{
        1,2,1,2,2,2,2,2,1,5,1,1,3,3,3,4,
        2,2,2,2,2,2,2,2,1,3,1,1,3,3,3,4,
        3,2,4,2,2,2,2,2,1,5,1,1,3,3,3,4,
        2,2,2,2,2,2,2,2,1,3,1,1,3,3,3,4,
        1,2,2,2,3,2,2,2,1,5,1,1,3,3,3,4,
        2,2,2,2,3,2,2,2,1,3,1,1,4,3,3,4,
        1,2,3,2,2,2,2,2,1,5,1,1,3,3,3,4,
        2,2,2,2,2,2,2,2,1,3,1,1,3,3,3,4,
        2,2,3,2,2,2,2,2,1,5,1,1,3,3,3,4,
        2,2,2,2,2,2,2,2,1,3,1,1,3,3,3,4,
        6,2,6,2,2,2,2,2,1,5,1,1,3,3,3,4,
        2,2,2,2,2,2,2,2,1,3,1,1,3,3,3,4,
        6,2,2,2,2,2,2,2,1,5,1,1,3,3,3,4,
        2,2,2,2,2,2,2,2,1,3,1,1,3,3,3,4,
        6,2,2,2,2,2,2,2,1,5,1,1,3,3,3,4,
        2,2,2,2,3,2,2,2,1,3,1,1,3,3,3,4
    };

endpackage

// ===== design/ift_collect.sv =====
// ----------------------------------------------------------------------------
// ift_collect
// Record collector: opcode decode, operand gathering, vector pairing and
// result assembly for one access per step.
// ----------------------------------------------------------------------------
module ift_collect (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  ift_pkg::ift_item_t   item,
    input  logic                 trace_enable,
    output logic                 res_valid,
    output ift_pkg::ift_result_t res
);
    import ift_pkg::*;

    logic        collecting_reg,     collecting_next;
    logic [7:0]  rec_bank_reg,       rec_bank_next;
    logic [15:0] rec_pc_reg,         rec_pc_next;
    logic [7:0]  rec_bytes_reg [4];
    logic [7:0]  rec_bytes_next [4];
    logic [2:0]  byte_count_reg,     byte_count_next;
    logic [2:0]  rec_length_reg,     rec_length_next;
    logic        vector_pending_reg, vector_pending_next;
    logic [15:0] vector_address_reg, vector_address_next;
    logic [7:0]  vector_low_reg,     vector_low_next;

    logic        insn_emit;
    logic        vec_emit;
    logic [2:0]  len_code;
    logic [4:0]  op_mode;
    logic [23:0] operand;
    logic [15:0] target;

    always_comb
    begin
        collecting_next     = collecting_reg;
        rec_bank_next       = rec_bank_reg;
        rec_pc_next         = rec_pc_reg;
        rec_bytes_next      = rec_bytes_reg;
        byte_count_next     = byte_count_reg;
        rec_length_next     = rec_length_reg;
        vector_pending_next = vector_pending_reg;
        vector_address_next = vector_address_reg;
        vector_low_next     = vector_low_reg;
        insn_emit           = 1'b0;
        vec_emit            = 1'b0;
        len_code            = LEN_TAB[item.data];
        if (step)
        begin
            unique case (item.mode)
                KIND_FETCH:
                begin
                    if (trace_enable)
                    begin
                        if (collecting_reg)
                        begin
                            if (byte_count_reg < LEN_MAX)
                            begin
                                rec_bytes_next[byte_count_reg[1:0]] = item.data;
                            end
                            byte_count_next = byte_count_reg + 3'd1;
                        end
                        else
                        begin
                            rec_bank_next     = item.bank;
                            rec_pc_next       = item.address;
                            rec_bytes_next[0] = item.data;
                            byte_count_next   = 3'd1;
                            if (len_code == LEN_M)
                            begin
                                rec_length_next = item.m_flag ? 3'd2 : 3'd3;
                            end
                            else if (len_code == LEN_X)
                            begin
                                rec_length_next = item.x_flag ? 3'd2 : 3'd3;
                            end
                            else
                            begin
                                rec_length_next = len_code;
                            end
                            collecting_next = 1'b1;
                        end
                        if (byte_count_next >= rec_length_next)
                        begin
                            collecting_next = 1'b0;
                            insn_emit       = 1'b1;
                        end
                    end
                end
                KIND_VECTOR:
                begin
                    if (vector_pending_reg)
                    begin
                        vector_pending_next = 1'b0;
                        vec_emit            = 1'b1;
                    end
                    else
                    begin
                        vector_pending_next = 1'b1;
                        vector_address_next = item.address;
                        vector_low_next     = item.data;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        op_mode = MODE_TAB[rec_bytes_next[0]];
        operand = '0;
        if (rec_length_next >= 3'd2)
        begin
            operand[7:0] = rec_bytes_next[1];
        end
        if (rec_length_next >= 3'd3)
        begin
            operand[15:8] = rec_bytes_next[2];
        end
        if (rec_length_next >= 3'd4)
        begin
            operand[23:16] = rec_bytes_next[3];
        end
        if (op_mode == MODE_PCR)
        begin
            target = rec_pc_next + 16'd2 + {{8{operand[7]}}, operand[7:0]};
        end
        else if (op_mode == MODE_PCRL)
        begin
            target = rec_pc_next + 16'd3 + operand[15:0];
        end
        else
        begin
            target = '0;
        end

        res       = '0;
        res_valid = insn_emit | vec_emit;
        if (insn_emit)
        begin
            res.record_kind    = REC_INSN;
            res.record_bank    = rec_bank_next;
            res.record_address = rec_pc_next;
            res.opcode         = rec_bytes_next[0];
            res.operand        = operand;
            res.length         = rec_length_next;
            res.addr_mode      = op_mode;
            res.branch_target  = target;
        end
        else if (vec_emit)
        begin
            res.record_kind    = REC_VECTOR;
            res.record_address = vector_address_reg;
            res.vector_value   = {item.data, vector_low_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            collecting_reg     <= 1'b0;
            rec_bank_reg       <= '0;
            rec_pc_reg         <= '0;
            byte_count_reg     <= '0;
            rec_length_reg     <= '0;
            vector_pending_reg <= 1'b0;
            vector_address_reg <= '0;
            vector_low_reg     <= '0;
        end
        else
        begin
            collecting_reg     <= collecting_next;
            rec_bank_reg       <= rec_bank_next;
            rec_pc_reg         <= rec_pc_next;
            byte_count_reg     <= byte_count_next;
            rec_length_reg     <= rec_length_next;
            vector_pending_reg <= vector_pending_next;
            vector_address_reg <= vector_address_next;
            vector_low_reg     <= vector_low_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_bytes_reg <= rec_bytes_next;
    end

endmodule

// ===== design/instruction_fetch_tracer_core.sv =====
// ----------------------------------------------------------------------------
// instruction_fetch_tracer_core
// Bus read tracer: collects instruction records and vector fetch records.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one bus read per beat (kind in tuser, address, data and
//   the M/X flags in tdata). m_axis carries one record per beat: an
//   instruction record once its last byte has been read, or a vector record
//   on the second read of a vector pair. Reads that complete nothing give
//   no beat.
//   cfg_valid/cfg_data write trace_enable; cfg_ready is always high. Write
//   it only while no reads are in flight.
//   Throughput: one read per cycle while m_axis does not stall. Each read is
//   decoded combinationally between the input register and the record
//   register. A record is offered on m_axis once the read that completes it
//   has passed the input register and been decoded into the record register.
//   Reset clears tracing, any open record and any pending vector half.
//   When m_axis stalls, the record register holds and the input register
//   takes one more read; s_axis_tready drops only when both are full.
// ----------------------------------------------------------------------------
module instruction_fetch_tracer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // bank, address, data, m_flag, x_flag, pad
    input  logic [1:0]  s_axis_tuser,   // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // record_bank, record_address, opcode, operand,
                                        // length, addr_mode, branch_target, vector_value
    output logic        m_axis_tuser,   // record_kind
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);
    import ift_pkg::*;

    logic        trace_enable_reg;
    logic        in_valid_reg;
    ift_item_t   in_reg;
    logic        out_valid_reg;
    ift_result_t out_reg;
    logic        advance;
    logic        res_valid;
    ift_result_t res;

    assign advance       = in_valid_reg & (~out_valid_reg | m_axis_tready);
    assign s_axis_tready = ~in_valid_reg | advance;
    assign cfg_ready     = 1'b1;

    ift_collect u_collect (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .item         (in_reg),
        .trace_enable (trace_enable_reg),
        .res_valid    (res_valid),
        .res          (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trace_enable_reg <= 1'b0;
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                trace_enable_reg <= cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= res_valid;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_reg.mode    <= ift_kind_t'(s_axis_tuser);
            in_reg.bank    <= s_axis_tdata[7:0];
            in_reg.address <= s_axis_tdata[23:8];
            in_reg.data    <= s_axis_tdata[31:24];
            in_reg.m_flag  <= s_axis_tdata[32];
            in_reg.x_flag  <= s_axis_tdata[33];
        end
        if (advance && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.record_kind;
    assign m_axis_tdata  = {out_reg.vector_value, out_reg.branch_target, out_reg.addr_mode,
                            out_reg.length, out_reg.operand, out_reg.opcode,
                            out_reg.record_address, out_reg.record_bank};

`ifndef SYNTH
    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_axis_tready |-> !advance)
        else $error("input stage advanced into a stalled record register");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_axis_tready)
        else $error("empty input stage not ready");

    a_insn_length: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && out_reg.record_kind == REC_INSN |->
            out_reg.length != 3'd0 && out_reg.length <= LEN_MAX && out_reg.vector_value == '0)
        else $error("instruction record with bad length or vector value");

    a_vector_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && out_reg.record_kind == REC_VECTOR |->
            out_reg.opcode == '0 && out_reg.length == '0 && out_reg.record_bank == '0)
        else $error("vector record carries instruction fields");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for instruction_fetch_tracer_core. Bus reads are driven
// on s_axis with random gaps. A predictor rebuilds the instruction and vector
// records, and every m_axis beat is checked field by field against the oldest
// predicted record.
// ----------------------------------------------------------------------------
module tb;
    import ift_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int DRAIN_CYCLES = 6;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 3000;
    localparam int NUM_PHASES   = 7;
    localparam bit PHASE_TRACE [NUM_PHASES] = '{1, 0, 1, 1, 0, 1, 1};

    class record_predictor;
        bit          tracing;
        bit          collecting;
        logic [7:0]  rec_bank;
        logic [15:0] rec_pc;
        logic [7:0]  rec_bytes [4];
        logic [2:0]  byte_count;
        logic [2:0]  rec_length;
        bit          vec_pending;
        logic [15:0] vec_addr;
        logic [7:0]  vec_low;
        ift_result_t expected_records [$];
        int          errors;

        function new();
            tracing     = 1'b0;
            collecting  = 1'b0;
            rec_bank    = '0;
            rec_pc      = '0;
            byte_count  = '0;
            rec_length  = '0;
            vec_pending = 1'b0;
            vec_addr    = '0;
            vec_low     = '0;
            errors      = 0;
            foreach (rec_bytes[i])
                rec_bytes[i] = '0;
        endfunction

        function void add_expected(ift_result_t rec);
            expected_records.insert(expected_records.size(), rec);
        endfunction

        function ift_result_t finish_insn();
            ift_result_t rec;
            logic [7:0]  op;
            logic [15:0] offset;
            int          i;
            rec = '0;
            op = rec_bytes[0];
            rec.record_kind    = REC_INSN;
            rec.record_bank    = rec_bank;
            rec.record_address = rec_pc;
            rec.opcode         = op;
            for (i = 1; i < 4; i++)
                if (i < rec_length)
                    rec.operand[8*(i-1) +: 8] = rec_bytes[i];
            rec.length    = rec_length;
            rec.addr_mode = MODE_TAB[op];
            if (rec.addr_mode == MODE_PCR)
            begin
                offset = {{8{rec.operand[7]}}, rec.operand[7:0]};
                rec.branch_target = rec_pc + 16'd2 + offset;
            end
            else if (rec.addr_mode == MODE_PCRL)
                rec.branch_target = rec_pc + 16'd3 + rec.operand[15:0];
            return rec;
        endfunction

        function void note_read(ift_item_t rd);
            logic [2:0]  code;
            ift_result_t rec;
            case (rd.mode)
                KIND_FETCH:
                    if (tracing)
                    begin
                        if (collecting)
                        begin
                            if (byte_count < 3'd4)
                                rec_bytes[byte_count[1:0]] = rd.data;
                            byte_count = byte_count + 3'd1;
                        end
                        else
                        begin
                            code = LEN_TAB[rd.data];
                            rec_bank     = rd.bank;
                            rec_pc       = rd.address;
                            rec_bytes[0] = rd.data;
                            byte_count   = 3'd1;
                            if (code == LEN_M)
                                rec_length = rd.m_flag ? 3'd2 : 3'd3;
                            else if (code == LEN_X)
                                rec_length = rd.x_flag ? 3'd2 : 3'd3;
                            else
                                rec_length = code;
                            collecting = 1'b1;
                        end
                        if (byte_count >= rec_length)
                        begin
                            collecting = 1'b0;
                            add_expected(finish_insn());
                        end
                    end
                KIND_VECTOR:
                    if (vec_pending)
                    begin
                        vec_pending = 1'b0;
                        rec = '0;
                        rec.record_kind    = REC_VECTOR;
                        rec.record_address = vec_addr;
                        rec.vector_value   = {rd.data, vec_low};
                        add_expected(rec);
                    end
                    else
                    begin
                        vec_pending = 1'b1;
                        vec_addr    = rd.address;
                        vec_low     = rd.data;
                    end
                default: ;
            endcase
        endfunction

        task report(string msg);
            $display("%0t ns mismatch: %s", $time, msg);
            errors++;
        endtask

        task compare_field(string name, logic [23:0] got, logic [23:0] want);
            if (got !== want)
                report($sformatf("%s got %0h, expected %0h", name, got, want));
        endtask

        task check_record(ift_result_t got);
            ift_result_t want;
            if (expected_records.size() == 0)
                report("record beat with no record pending");
            else
            begin
                want = expected_records.pop_front();
                compare_field("record_kind", 24'(got.record_kind), 24'(want.record_kind));
                compare_field("record_bank", 24'(got.record_bank), 24'(want.record_bank));
                compare_field("record_address", 24'(got.record_address),
                              24'(want.record_address));
                compare_field("opcode", 24'(got.opcode), 24'(want.opcode));
                compare_field("operand", got.operand, want.operand);
                compare_field("length", 24'(got.length), 24'(want.length));
                compare_field("addr_mode", 24'(got.addr_mode), 24'(want.addr_mode));
                compare_field("branch_target", 24'(got.branch_target),
                              24'(want.branch_target));
                compare_field("vector_value", 24'(got.vector_value), 24'(want.vector_value));
            end
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // bank, address, data, m_flag, x_flag, pad
    logic [1:0]  s_axis_tuser;   // mode
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [95:0] m_axis_tdata;   // record_bank, record_address, opcode, operand,
                                 // length, addr_mode, branch_target, vector_value
    logic        m_axis_tuser;   // record_kind
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;

    record_predictor predictor = new();
    bit hold_off = 1'b0;
    bit calm     = 1'b0;

    instruction_fetch_tracer_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // beat monitors
    always @(posedge clk)
    begin
        ift_item_t   rd;
        ift_result_t got;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            rd.mode    = ift_kind_t'(s_axis_tuser);
            rd.bank    = s_axis_tdata[7:0];
            rd.address = s_axis_tdata[23:8];
            rd.data    = s_axis_tdata[31:24];
            rd.m_flag  = s_axis_tdata[32];
            rd.x_flag  = s_axis_tdata[33];
            predictor.note_read(rd);
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.record_kind    = m_axis_tuser;
            got.record_bank    = m_axis_tdata[7:0];
            got.record_address = m_axis_tdata[23:8];
            got.opcode         = m_axis_tdata[31:24];
            got.operand        = m_axis_tdata[55:32];
            got.length         = m_axis_tdata[58:56];
            got.addr_mode      = m_axis_tdata[63:59];
            got.branch_target  = m_axis_tdata[79:64];
            got.vector_value   = m_axis_tdata[95:80];
            predictor.check_record(got);
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready) || !rst_n)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    // record sink with random back-pressure and one long hold-off
    initial
    begin
        m_axis_tready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_off = 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 19) - 1) @(negedge clk);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    task automatic send_item(ift_item_t rd);
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, rd.x_flag, rd.m_flag, rd.data, rd.address, rd.bank};
        s_axis_tuser  <= rd.mode;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic send(ift_kind_t kind, logic [7:0] bank, logic [15:0] address,
                        logic [7:0] data, logic m_flag, logic x_flag);
        ift_item_t rd;
        rd.mode    = kind;
        rd.bank    = bank;
        rd.address = address;
        rd.data    = data;
        rd.m_flag  = m_flag;
        rd.x_flag  = x_flag;
        send_item(rd);
    endtask

    task automatic sender_gap(int cycles);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic wait_drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (predictor.expected_records.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_trace(logic value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        predictor.tracing = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic ift_item_t random_read();
        ift_item_t rd;
        int        sel;
        sel = $urandom_range(0, 99);
        if (sel < 74)
            rd.mode = KIND_FETCH;
        else if (sel < 88)
            rd.mode = KIND_VECTOR;
        else if (sel < 96)
            rd.mode = KIND_OTHER;
        else
            rd.mode = KIND_SPARE;
        rd.bank = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 7))
            0:       rd.address = 16'h0000;
            1:       rd.address = 16'hFFFF;
            default: rd.address = 16'($urandom_range(0, 65535));
        endcase
        rd.data   = 8'($urandom_range(0, 255));
        rd.m_flag = 1'($urandom_range(0, 1));
        rd.x_flag = 1'($urandom_range(0, 1));
        return rd;
    endfunction

    initial
    begin
        int p;
        int n;
        int count;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_FETCH;
        cfg_valid     = 1'b0;
        cfg_data      = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_trace(1'b1);
        // BRK and COP at the address extremes
        send(KIND_FETCH, 8'hFF, 16'hFFFF, 8'h00, 1'b1, 1'b1);
        send(KIND_FETCH, 8'h00, 16'h0000, 8'h02, 1'b0, 1'b0);
        // immediates sized by M and X
        send(KIND_FETCH, 8'h12, 16'h8000, 8'hA9, 1'b1, 1'b0);
        send(KIND_FETCH, 8'h00, 16'h0000, 8'hFF, 1'b0, 1'b0);
        send(KIND_FETCH, 8'h12, 16'h8002, 8'hA9, 1'b0, 1'b1);
        send(KIND_FETCH, 8'h00, 16'h0000, 8'h00, 1'b1, 1'b1);
        send(KIND_FETCH, 8'h00, 16'h0000, 8'hFF, 1'b1, 1'b1);
        send(KIND_FETCH, 8'h34, 16'h1234, 8'hA2, 1'b1, 1'b0);
        send(KIND_FETCH, 8'h00, 16'h0000, 8'h34, 1'b0, 1'b0);
        send(KIND_FETCH, 8'h00, 16'h0000, 8'h12, 1'b0, 1'b0);
        // long call, four bytes
        send(KIND_FETCH, 8'hC0, 16'h4000, 8'h22, 1'b1, 1'b1);
        send(KIND_FETCH, 8'h00, 16'h0000, 8'h56, 1'b1, 1'b1);
        send(KIND_FETCH, 8'h00, 16'h0000, 8'h34, 1'b1, 1'b1);
        send(KIND_FETCH, 8'h00, 16'h0000, 8'h12, 1'b1, 1'b1);
        // branches that wrap below zero and past the top
        send(KIND_FETCH, 8'h00, 16'h0001, 8'h80, 1'b1, 1'b1);
        send(KIND_FETCH, 8'h00, 16'h0000, 8'h80, 1'b1, 1'b1);
        send(KIND_FETCH, 8'hFF, 16'hFFFF, 8'h82, 1'b0, 1'b0);
        send(KIND_FETCH, 8'h00, 16'h0000, 8'hFF, 1'b0, 1'b0);
        send(KIND_FETCH, 8'h00, 16'h0000, 8'hFF, 1'b0, 1'b0);
        // SBC [d]
        send(KIND_FETCH, 8'h01, 16'h0100, 8'hE7, 1'b1, 1'b1);
        send(KIND_FETCH, 8'h00, 16'h0000, 8'h10, 1'b1, 1'b1);
        // other and spare reads inside a record
        send(KIND_FETCH, 8'h02, 16'h0200, 8'hAD, 1'b1, 1'b1);
        send(KIND_OTHER, 8'hFF, 16'hFFFF, 8'hFF, 1'b1, 1'b1);
        send(KIND_SPARE, 8'hFF, 16'hFFFF, 8'hFF, 1'b1, 1'b1);
        send(KIND_FETCH, 8'h00, 16'h0000, 8'h00, 1'b1, 1'b1);
        send(KIND_FETCH, 8'h00, 16'h0000, 8'h80, 1'b1, 1'b1);
        // record left open across a tracing pause, vectors still reported
        send(KIND_FETCH, 8'h03, 16'h0300, 8'h4C, 1'b1, 1'b1);
        send(KIND_FETCH, 8'h00, 16'h0000, 8'hCD, 1'b1, 1'b1);
        wait_drain();
        write_trace(1'b0);
        send(KIND_FETCH, 8'hFF, 16'hFFFF, 8'h55, 1'b0, 1'b0);
        send(KIND_VECTOR, 8'hAB, 16'hFFFC, 8'h00, 1'b0, 1'b0);
        send(KIND_VECTOR, 8'hCD, 16'hFFFD, 8'hFF, 1'b1, 1'b1);
        wait_drain();
        write_trace(1'b1);
        send(KIND_FETCH, 8'h00, 16'h0000, 8'hAB, 1'b1, 1'b1);

        for (p = 0; p < NUM_PHASES; p++)
        begin
            wait_drain();
            write_trace(PHASE_TRACE[p]);
            if (p == NUM_PHASES - 1)
                calm = 1'b1;
            count = PHASE_TRACE[p] ? 100 : 40;
            for (n = 0; n < count; n++)
            begin
                if (p == 2 && n == 30)
                    hold_off = 1'b1;
                if (p == 3 && n == 50)
                    wait_drain();
                if (!calm && $urandom_range(0, 5) == 0)
                    sender_gap($urandom_range(1, 19));
                send_item(random_read());
            end
        end
        wait_drain();

        if (predictor.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/ift_pkg.sv
design/ift_collect.sv
design/instruction_fetch_tracer_core.sv
tb/tb.sv
